// ===== sv/bsfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder package
// Shared types and constants for the frame encoder core: transfer payloads,
// the queued item descriptor, the emit phase of the back end and the
// configuration register map.
// ----------------------------------------------------------------------------
package bsfe_pkg;

    // Field widths of one input item
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int SEQ_W  = 5;
    localparam int KIND_W = 5;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'd1;

    localparam logic [BYTE_W-1:0] CRC_POLY_RESET     = 8'h07;
    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h7E;

    // Depth of the queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input transfer payload
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_start;
        logic              frame_end;
        logic [LEN_W-1:0]  length_field;
        logic [SEQ_W-1:0]  sequence_number;
        logic [KIND_W-1:0] frame_kind;
    } in_item_t;

    // Output transfer payload
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              frame_done;
        logic              run_last;
    } out_item_t;

    // Classified item as held in the queue
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              is_start;
        logic              is_end;
        logic              needs_fill;
        logic [BYTE_W-1:0] hdr_hi;
        logic [BYTE_W-1:0] hdr_lo;
    } desc_t;

    // Which byte of the current item the back end emits next
    typedef enum logic [2:0] {
        PH_ENTRY,
        PH_MARK,
        PH_H1,
        PH_H2,
        PH_DATA,
        PH_FILL,
        PH_CRC
    } phase_t;

endpackage

// ===== sv/bsfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame encoder front end
// Accepts input transfers while the queue has room and classifies each item:
// packs the two header bytes and flags whether a fill byte must follow.
// ----------------------------------------------------------------------------
module bsfe_front #(
    parameter int MAX_PAYLOAD = 63
) (
    input  logic             up_valid,
    output logic             up_stall,
    input  bsfe_pkg::in_item_t up_item,
    input  logic             queue_full,
    output logic             push,
    output bsfe_pkg::desc_t  push_desc
);
    import bsfe_pkg::*;

    localparam logic [LEN_W-1:0]  LEN_CAP   = LEN_W'(MAX_PAYLOAD);
    localparam logic [BYTE_W-1:0] ESC_A     = 8'h88;
    localparam logic [BYTE_W-1:0] ESC_B     = 8'h81;

    logic [LEN_W-1:0] len_sat;

    // Handshake: take an item whenever the queue can hold it
    assign up_stall = queue_full;
    assign push     = up_valid && !queue_full;

    // Header length saturates at the largest payload size
    assign len_sat = (up_item.length_field > LEN_CAP) ? LEN_CAP : up_item.length_field;

    // Classification of the item
    always_comb
    begin
        push_desc.data_byte  = up_item.payload_byte;
        push_desc.is_start   = up_item.frame_start;
        push_desc.is_end     = up_item.frame_end;
        push_desc.needs_fill = (up_item.payload_byte == ESC_A) ||
                               (up_item.payload_byte == ESC_B);
        push_desc.hdr_hi     = {len_sat, up_item.sequence_number[4:3]};
        push_desc.hdr_lo     = {up_item.sequence_number[2:0], up_item.frame_kind};
    end

endmodule

// ===== sv/bsfe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame encoder item queue
// A short first-in first-out queue of classified items between the front and
// back ends, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module bsfe_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bsfe_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output bsfe_pkg::desc_t head
);
    import bsfe_pkg::*;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== sv/bsfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame encoder back end
// Walks the head item of the queue one output byte per cycle unless the output
// stalls: marker, header, data, fill and CRC as the item needs, updating the
// running CRC on every byte from header to fill, into a registered output stage.
// ----------------------------------------------------------------------------
module bsfe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  bsfe_pkg::desc_t     head,
    output logic                pop,
    input  logic [7:0]          crc_poly,
    input  logic [7:0]          start_marker,
    output logic                dn_valid,
    input  logic                dn_stall,
    output bsfe_pkg::out_item_t dn_item
);
    import bsfe_pkg::*;

    localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

    phase_t            phase_reg, phase_next;
    phase_t            cur_phase;
    phase_t            step_next;
    logic [BYTE_W-1:0] crc_reg, crc_next;
    logic [BYTE_W-1:0] crc_fed;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_done;
    logic              emit_last;
    logic              feed_crc;
    logic              clear_crc;
    logic              load;
    logic              dn_valid_reg, dn_valid_next;
    out_item_t         dn_item_reg;

    // One MSB-first CRC-8 update over a whole byte
    function automatic logic [7:0] crc_feed(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

    // A byte of a queued item goes out when the output stage is empty or draining
    assign load = head_valid && (!dn_valid_reg || !dn_stall);

    // At the start of an item the phase follows its start flag; an empty queue
    // holds no valid flag to look at.
    assign cur_phase = (phase_reg == PH_ENTRY)
                     ? ((head_valid && head.is_start) ? PH_MARK : PH_DATA)
                     : phase_reg;

    assign crc_fed = crc_feed(crc_reg, emit_byte, crc_poly);

    // Phase sequencing and byte selection
    always_comb
    begin
        emit_byte = head.data_byte;
        emit_done = 1'b0;
        emit_last = 1'b0;
        feed_crc  = 1'b0;
        clear_crc = 1'b0;
        step_next = PH_ENTRY;
        unique case (cur_phase)
            PH_MARK:
            begin
                emit_byte = start_marker;
                clear_crc = 1'b1;
                step_next = PH_H1;
            end
            PH_H1:
            begin
                emit_byte = head.hdr_hi;
                feed_crc  = 1'b1;
                step_next = PH_H2;
            end
            PH_H2:
            begin
                emit_byte = head.hdr_lo;
                feed_crc  = 1'b1;
                step_next = PH_DATA;
            end
            PH_DATA:
            begin
                emit_byte = head.data_byte;
                feed_crc  = 1'b1;
                emit_last = !head.needs_fill && !head.is_end;
                step_next = head.needs_fill ? PH_FILL : (head.is_end ? PH_CRC : PH_ENTRY);
            end
            PH_FILL:
            begin
                emit_byte = FILL_BYTE;
                feed_crc  = 1'b1;
                emit_last = !head.is_end;
                step_next = head.is_end ? PH_CRC : PH_ENTRY;
            end
            PH_CRC:
            begin
                emit_byte = crc_reg;
                emit_done = 1'b1;
                emit_last = 1'b1;
                clear_crc = 1'b1;
                step_next = PH_ENTRY;
            end
            PH_ENTRY:
            begin
                step_next = PH_ENTRY;
            end
        endcase

        phase_next = load ? step_next : phase_reg;

        crc_next = crc_reg;
        if (load && clear_crc)
        begin
            crc_next = '0;
        end
        else if (load && feed_crc)
        begin
            crc_next = crc_fed;
        end
    end

    assign pop = load && emit_last;

    // Output stage occupancy
    always_comb
    begin
        dn_valid_next = dn_valid_reg;
        if (load)
        begin
            dn_valid_next = 1'b1;
        end
        else if (!dn_stall)
        begin
            dn_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_ENTRY;
            crc_reg      <= '0;
            dn_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            crc_reg      <= crc_next;
            dn_valid_reg <= dn_valid_next;
        end
    end

    // Output payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dn_item_reg.out_byte   <= emit_byte;
            dn_item_reg.frame_done <= emit_done;
            dn_item_reg.run_last   <= emit_last;
        end
    end

    assign dn_valid = dn_valid_reg;
    assign dn_item  = dn_item_reg;

    // An item part-way through emission stays at the head of the queue
    a_mid_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_ENTRY) |-> head_valid)
        else $error("item left the queue before all its bytes were sent");

    // Finishing an item returns the sequencer to its entry point
    a_pop_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (phase_reg == PH_ENTRY))
        else $error("phase not back at entry after an item finished");

    // The CRC byte always closes the item's run of bytes
    a_crc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && emit_done) |-> pop)
        else $error("CRC byte emitted without finishing the item");

    // A marker restarts the running CRC
    a_marker_clears_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (cur_phase == PH_MARK)) |=> (crc_reg == '0))
        else $error("running CRC not cleared by the start marker");

endmodule

// ===== sv/byte_stuffed_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder core
// Encodes payload bytes into framed, byte-stuffed output with a CRC-8 trailer.
// ----------------------------------------------------------------------------
// Each accepted payload byte produces one to six output bytes: the start
// marker and two header bytes when it opens a frame, the byte itself, a 0xFF
// fill after 0x88 or 0x81, and the CRC-8 when it closes a frame. The back end
// emits one output byte per cycle while it holds an item and the output is
// not stalled; with the output never stalled, a plain data byte is taken
// every cycle. A two-item queue decouples input from output; when the queue
// is empty the first byte of an item passes through the queue entry and then
// the registered output stage before it is presented. The CRC is MSB-first,
// starts from zero and covers every byte from the header to the fill, so a
// receiver running the same CRC over those bytes and the CRC byte ends at
// zero. Write the polynomial and marker registers only while the core is
// idle.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_encoder_core #(
    parameter int MAX_PAYLOAD = 63
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bsfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsfe_pkg::BYTE_W-1:0]         cfg_data,
    input  logic                                up_valid,
    output logic                                up_stall,
    input  bsfe_pkg::in_item_t                  up_item,
    output logic                                dn_valid,
    input  logic                                dn_stall,
    output bsfe_pkg::out_item_t                 dn_item
);
    import bsfe_pkg::*;

    logic [BYTE_W-1:0] crc_poly_reg, crc_poly_next;
    logic [BYTE_W-1:0] start_marker_reg, start_marker_next;
    logic              push;
    desc_t             push_desc;
    logic              queue_full;
    logic              head_valid;
    desc_t             head;
    logic              pop;

    // Configuration registers
    always_comb
    begin
        crc_poly_next     = crc_poly_reg;
        start_marker_next = start_marker_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CRC_POLY:     crc_poly_next     = cfg_data;
                CFG_START_MARKER: start_marker_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_poly_reg     <= CRC_POLY_RESET;
            start_marker_reg <= START_MARKER_RESET;
        end
        else
        begin
            crc_poly_reg     <= crc_poly_next;
            start_marker_reg <= start_marker_next;
        end
    end

    // Front end: acceptance and classification
    bsfe_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .up_valid   (up_valid),
        .up_stall   (up_stall),
        .up_item    (up_item),
        .queue_full (queue_full),
        .push       (push),
        .push_desc  (push_desc)
    );

    // Queue between the two ends
    bsfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end: byte sequencing, CRC and output stage
    bsfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .crc_poly     (crc_poly_reg),
        .start_marker (start_marker_reg),
        .dn_valid     (dn_valid),
        .dn_stall     (dn_stall),
        .dn_item      (dn_item)
    );

endmodule
